// ----- rtl/core/floor_ceiling_texcoord_gen_core_assert.svh -----
// assertion macros for the floor and ceiling texcoord generator
// used by the top level; expects clk_i and rst_ni in scope
`ifndef FLOOR_CEILING_TEXCOORD_GEN_CORE_ASSERT_SVH
`define FLOOR_CEILING_TEXCOORD_GEN_CORE_ASSERT_SVH

// same-cycle implication
`define FCTG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fctg: assertion failed");

// next-cycle implication
`define FCTG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fctg: assertion failed");

`endif

// ----- rtl/core/fctg_pkg.sv -----
// shared constants and types for the floor and ceiling texcoord generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fctg_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int FLOOR_TEX_LOG2 = 6;
  localparam int CEIL_TEX_LOG2  = 6;

  localparam int ACC_W     = 48;
  localparam int COORD_W   = 12;
  localparam int DIM_W     = 13;
  localparam int POS_W     = 26;
  localparam int RAY_W     = 19;
  localparam int SPAN_W    = 20;
  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 3;

  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 13;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam int DIST_W = 29;
  localparam int PROD_W = DIST_W + SPAN_W;

  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_RAY_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_RAY_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_SPAN_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_SPAN_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd7;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/fctg_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on fctg_pkg
`timescale 1ns / 1ps
`default_nettype none

module fctg_div import fctg_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] num_i,
  input  wire logic [DIV_DEN_W-1:0] den_i,
  output logic      [DIV_NUM_W-1:0] quo_o,
  output div_stat_t                 stat_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W:0]   rem_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] den_q;

  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W+1:0] trial;
  logic                 ge;

  assign rem_sh = {rem_q[DIV_DEN_W-1:0], quo_q[DIV_NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = !trial[DIV_DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[DIV_DEN_W:0] : rem_sh;
      quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// ----- rtl/core/floor_ceiling_texcoord_gen_core.sv -----
// floor and ceiling texture coordinate generator, top level
// depends on fctg_pkg, fctg_div and floor_ceiling_texcoord_gen_core_assert.svh
//
// usage:
//   pixel requests (row_i, column_i) come in raster order on the input channel,
//   guarded by in_valid_i / in_stall_o; texel coordinates leave on the output
//   channel, guarded by out_valid_o / out_stall_i, one result per transfer in.
//   registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
//   must write them only while idle; the block does not enforce it. a request
//   with a nonzero column is answered in the cycle after its transfer; the block
//   takes the next request in that same cycle if the output is free. a request
//   with column zero runs the row set-up: one division for the row distance,
//   then per ray-span axis one multiply and one division by the screen width,
//   then one multiply per left-ray axis; the horizon row skips the first
//   division. one shared divider serves them all; input is stalled meanwhile.
//   an output register holds the result while out_stall_i is high; a new
//   request is taken only when that register is free or drains in that cycle.
//   reset clears the position and step state and loads the default registers.
`include "floor_ceiling_texcoord_gen_core_assert.svh"
`timescale 1ns / 1ps
`default_nettype none

module floor_ceiling_texcoord_gen_core import fctg_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [CFG_W-1:0]          cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [COORD_W-1:0]        row_i,
  input  wire logic [COORD_W-1:0]        column_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [FLOOR_TEX_LOG2-1:0]      floor_tex_u_o,
  output logic [FLOOR_TEX_LOG2-1:0]      floor_tex_v_o,
  output logic [CEIL_TEX_LOG2-1:0]       ceil_tex_u_o,
  output logic [CEIL_TEX_LOG2-1:0]       ceil_tex_v_o,
  output logic [COORD_W-1:0]             out_column_o,
  output logic [COORD_W-1:0]             floor_row_o,
  output logic [COORD_W-1:0]             mirror_row_o,
  output logic                           pixel_valid_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DDIST = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_POST  = 3'd3;
  localparam logic [2:0] S_DSTEP = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // configuration
  logic [POS_W-1:0]         player_x_q, player_y_q;
  logic signed [RAY_W-1:0]  left_x_q, left_y_q;
  logic signed [SPAN_W-1:0] span_x_q, span_y_q;
  logic [DIM_W-1:0]         sw_q, sh_q;

  // state
  logic [2:0]         state_q;
  logic [1:0]         k_q;
  logic [COORD_W-1:0] row_q, col_q;
  logic               pvalid_q, dist_neg_q, prod_neg_q;
  logic [DIST_W-1:0]  dist_mag_q;
  logic [PROD_W-1:0]  prod_q;
  logic [ACC_W-1:0]   acc_x_q, acc_y_q, step_x_q, step_y_q;

  // output register
  logic                      out_valid_q;
  logic [FLOOR_TEX_LOG2-1:0] fu_q, fv_q;
  logic [CEIL_TEX_LOG2-1:0]  cu_q, cv_q;
  logic [COORD_W-1:0]        ocol_q, orow_q, omir_q;
  logic                      opv_q;

  // divider
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  div_stat_t            div_stat;

  logic               in_xfer, out_free, out_load;
  logic [COORD_W-1:0] half, pmag;
  logic               p_zero, p_neg;
  logic [DIM_W-1:0]   w_eff;
  logic [DIV_NUM_W-1:0] num_dist, prod_hi;
  logic signed [SPAN_W-1:0] op_s;
  logic [SPAN_W-1:0]  op_mag;
  logic [PROD_W-1:0]  prod_d;
  logic [ACC_W-1:0]   quo_s, off_s;

  logic [COORD_W-1:0] ld_row, ld_col;
  logic               ld_pv;
  logic [ACC_W-1:0]   mag_x, mag_y;
  logic [FLOOR_TEX_LOG2-1:0] ftx, fty;
  logic [CEIL_TEX_LOG2-1:0]  ctx, cty;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // row set-up operands
  assign half   = sh_q[DIM_W-1:1];
  assign p_zero = (row_i == half);
  assign p_neg  = (row_i < half);
  assign pmag   = p_neg ? (half - row_i) : (row_i - half);
  assign w_eff  = (sw_q == '0) ? DIM_W'(1) : sw_q;
  assign num_dist = DIV_NUM_W'({sh_q, {(FRAC_BITS-1){1'b0}}});
  assign prod_hi  = prod_q[FRAC_BITS +: DIV_NUM_W];

  always_comb begin
    case (k_q)
      2'd0:    op_s = span_x_q;
      2'd1:    op_s = span_y_q;
      2'd2:    op_s = SPAN_W'(left_x_q);
      default: op_s = SPAN_W'(left_y_q);
    endcase
  end

  assign op_mag = op_s[SPAN_W-1] ? SPAN_W'(-op_s) : SPAN_W'(op_s);
  assign prod_d = PROD_W'(dist_mag_q) * PROD_W'(op_mag);

  assign quo_s = prod_neg_q ? -ACC_W'(div_quo) : ACC_W'(div_quo);
  assign off_s = prod_neg_q ? -ACC_W'(prod_hi) : ACC_W'(prod_hi);

  assign div_start = (state_q == S_IDLE && in_xfer && column_i == '0 && !p_zero) ||
                     (state_q == S_POST && !k_q[1]);
  assign div_num   = (state_q == S_IDLE) ? num_dist : prod_hi;
  assign div_den   = (state_q == S_IDLE) ? DIV_DEN_W'(pmag) : w_eff;

  fctg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  // texel taken from the fraction toward zero
  assign mag_x = acc_x_q[ACC_W-1] ? -acc_x_q : acc_x_q;
  assign mag_y = acc_y_q[ACC_W-1] ? -acc_y_q : acc_y_q;
  assign ftx = acc_x_q[ACC_W-1] ? -mag_x[FRAC_BITS-1 -: FLOOR_TEX_LOG2]
                                :  mag_x[FRAC_BITS-1 -: FLOOR_TEX_LOG2];
  assign fty = acc_y_q[ACC_W-1] ? -mag_y[FRAC_BITS-1 -: FLOOR_TEX_LOG2]
                                :  mag_y[FRAC_BITS-1 -: FLOOR_TEX_LOG2];
  assign ctx = acc_x_q[ACC_W-1] ? -mag_x[FRAC_BITS-1 -: CEIL_TEX_LOG2]
                                :  mag_x[FRAC_BITS-1 -: CEIL_TEX_LOG2];
  assign cty = acc_y_q[ACC_W-1] ? -mag_y[FRAC_BITS-1 -: CEIL_TEX_LOG2]
                                :  mag_y[FRAC_BITS-1 -: CEIL_TEX_LOG2];

  assign out_load = (state_q == S_IDLE && in_xfer && column_i != '0) ||
                    (state_q == S_OUT && out_free);
  assign ld_row   = (state_q == S_OUT) ? row_q : row_i;
  assign ld_col   = (state_q == S_OUT) ? col_q : column_i;
  assign ld_pv    = (state_q == S_OUT) ? pvalid_q : !p_zero;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= '0;
      player_y_q <= '0;
      left_x_q   <= '0;
      left_y_q   <= '0;
      span_x_q   <= '0;
      span_y_q   <= '0;
      sw_q       <= DIM_W'(640);
      sh_q       <= DIM_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PLAYER_X:      player_x_q <= cfg_wdata_i[POS_W-1:0];
        REG_PLAYER_Y:      player_y_q <= cfg_wdata_i[POS_W-1:0];
        REG_LEFT_RAY_X:    left_x_q   <= cfg_wdata_i[RAY_W-1:0];
        REG_LEFT_RAY_Y:    left_y_q   <= cfg_wdata_i[RAY_W-1:0];
        REG_RAY_SPAN_X:    span_x_q   <= cfg_wdata_i[SPAN_W-1:0];
        REG_RAY_SPAN_Y:    span_y_q   <= cfg_wdata_i[SPAN_W-1:0];
        REG_SCREEN_WIDTH:  sw_q       <= cfg_wdata_i[DIM_W-1:0];
        REG_SCREEN_HEIGHT: sh_q       <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      acc_x_q  <= '0;
      acc_y_q  <= '0;
      step_x_q <= '0;
      step_y_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (column_i == '0) begin
              k_q     <= '0;
              state_q <= p_zero ? S_MUL : S_DDIST;
            end else begin
              acc_x_q <= acc_x_q + step_x_q;
              acc_y_q <= acc_y_q + step_y_q;
            end
          end
        end
        S_DDIST: begin
          if (div_stat.done) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_POST;
        end
        S_POST: begin
          if (!k_q[1]) begin
            state_q <= S_DSTEP;
          end else begin
            if (k_q[0]) begin
              acc_y_q <= ACC_W'(player_y_q) + off_s;
              state_q <= S_OUT;
            end else begin
              acc_x_q <= ACC_W'(player_x_q) + off_s;
              state_q <= S_MUL;
            end
            k_q <= k_q + 1'b1;
          end
        end
        S_DSTEP: begin
          if (div_stat.done) begin
            if (k_q[0]) begin
              step_y_q <= quo_s;
            end else begin
              step_x_q <= quo_s;
            end
            k_q     <= k_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            acc_x_q <= acc_x_q + step_x_q;
            acc_y_q <= acc_y_q + step_y_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // set-up datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_xfer && column_i == '0) begin
      row_q      <= row_i;
      col_q      <= column_i;
      pvalid_q   <= !p_zero;
      dist_neg_q <= p_neg;
      if (p_zero) begin
        dist_mag_q <= '0;
      end
    end
    if (state_q == S_DDIST && div_stat.done) begin
      dist_mag_q <= div_quo[DIST_W-1:0];
    end
    if (state_q == S_MUL) begin
      prod_q     <= prod_d;
      prod_neg_q <= dist_neg_q ^ op_s[SPAN_W-1];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      fu_q   <= ftx;
      fv_q   <= fty;
      cu_q   <= ctx;
      cv_q   <= cty;
      ocol_q <= ld_col;
      orow_q <= ld_row;
      omir_q <= sh_q[COORD_W-1:0] - COORD_W'(1) - ld_row;
      opv_q  <= ld_pv;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign floor_tex_u_o = fu_q;
  assign floor_tex_v_o = fv_q;
  assign ceil_tex_u_o  = cu_q;
  assign ceil_tex_v_o  = cv_q;
  assign out_column_o  = ocol_q;
  assign floor_row_o   = orow_q;
  assign mirror_row_o  = omir_q;
  assign pixel_valid_o = opv_q;

  `FCTG_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy)
  `FCTG_ASSERT_NXT(a_pixel_next, in_xfer && column_i != '0, out_valid_o)
  `FCTG_ASSERT_IMP(a_ddist_div_live, state_q == S_DDIST, div_stat.busy || div_stat.done)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for floor_ceiling_texcoord_gen_core: raster pixel requests,
// register settings and random idling, with every output transfer checked in order
// depends on fctg_pkg and the core rtl
`timescale 1ns / 1ps

module testbench;
  import fctg_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    int floor_u;
    int floor_v;
    int ceil_u;
    int ceil_v;
    int column;
    int floor_row;
    int mirror_row;
    int pix_valid;
  } texel_set_t;

  typedef struct {
    logic [POS_W-1:0]  player_x;
    logic [POS_W-1:0]  player_y;
    logic [RAY_W-1:0]  left_x;
    logic [RAY_W-1:0]  left_y;
    logic [SPAN_W-1:0] span_x;
    logic [SPAN_W-1:0] span_y;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } view_cfg_t;

  class texcoord_tracker;
    view_cfg_t        view;
    logic [ACC_W-1:0] world_x;
    logic [ACC_W-1:0] world_y;
    logic [ACC_W-1:0] step_x;
    logic [ACC_W-1:0] step_y;
    texel_set_t       pending[$];
    int               errors;

    function new();
      view.player_x = '0;
      view.player_y = '0;
      view.left_x   = '0;
      view.left_y   = '0;
      view.span_x   = '0;
      view.span_y   = '0;
      view.width    = DIM_W'(640);
      view.height   = DIM_W'(480);
      world_x = '0;
      world_y = '0;
      step_x  = '0;
      step_y  = '0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_PLAYER_X:      view.player_x = data[POS_W-1:0];
        REG_PLAYER_Y:      view.player_y = data[POS_W-1:0];
        REG_LEFT_RAY_X:    view.left_x   = data[RAY_W-1:0];
        REG_LEFT_RAY_Y:    view.left_y   = data[RAY_W-1:0];
        REG_RAY_SPAN_X:    view.span_x   = data[SPAN_W-1:0];
        REG_RAY_SPAN_Y:    view.span_y   = data[SPAN_W-1:0];
        REG_SCREEN_WIDTH:  view.width    = data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: view.height   = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // fraction taken toward zero, negative positions wrap in two's complement
    function int texel_of(logic [ACC_W-1:0] acc, int lg);
      logic [ACC_W-1:0] mag;
      int               t;
      mag = acc[ACC_W-1] ? ~acc + 1'b1 : acc;
      t = int'(mag[FRAC_BITS-1:0]) >> (FRAC_BITS - lg);
      if (acc[ACC_W-1]) t = -t;
      return t & ((1 << lg) - 1);
    endfunction

    function void take_request(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
      longint     rr;
      longint     hh;
      longint     ww;
      longint     p;
      longint     row_dist;
      longint     t;
      texel_set_t e;
      rr = longint'(r);
      hh = longint'(view.height);
      ww = (view.width == '0) ? 64'sd1 : longint'(view.width);
      p  = rr - (hh >> 1);
      if (c == '0) begin
        row_dist = 0;
        if (p != 0) begin
          row_dist = (hh <<< (FRAC_BITS - 1)) / ((p < 0) ? -p : p);
          if (p < 0) row_dist = -row_dist;
        end
        t = row_dist * longint'($signed(view.span_x)) / (ww <<< FRAC_BITS);
        step_x = t[ACC_W-1:0];
        t = row_dist * longint'($signed(view.span_y)) / (ww <<< FRAC_BITS);
        step_y = t[ACC_W-1:0];
        t = longint'(view.player_x)
            + row_dist * longint'($signed(view.left_x)) / (64'sd1 <<< FRAC_BITS);
        world_x = t[ACC_W-1:0];
        t = longint'(view.player_y)
            + row_dist * longint'($signed(view.left_y)) / (64'sd1 <<< FRAC_BITS);
        world_y = t[ACC_W-1:0];
      end
      e.floor_u   = texel_of(world_x, FLOOR_TEX_LOG2);
      e.floor_v   = texel_of(world_y, FLOOR_TEX_LOG2);
      e.ceil_u    = texel_of(world_x, CEIL_TEX_LOG2);
      e.ceil_v    = texel_of(world_y, CEIL_TEX_LOG2);
      e.column    = int'(c);
      e.floor_row = int'(r);
      t = hh - 1 - rr;
      e.mirror_row = int'(t[COORD_W-1:0]);
      e.pix_valid  = (p != 0) ? 1 : 0;
      world_x = world_x + step_x;
      world_y = world_y + step_y;
      pending.push_back(e);
    endfunction

    function void check_field(string name, int want, int seen);
      if (want != seen) begin
        if (errors < MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void compare_texels(texel_set_t got);
      texel_set_t e;
      if (pending.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: output transfer with nothing pending, expected none, actual column %0d",
                   $time, got.column);
        errors++;
        return;
      end
      e = pending.pop_front();
      check_field("floor_tex_u", e.floor_u, got.floor_u);
      check_field("floor_tex_v", e.floor_v, got.floor_v);
      check_field("ceil_tex_u", e.ceil_u, got.ceil_u);
      check_field("ceil_tex_v", e.ceil_v, got.ceil_v);
      check_field("out_column", e.column, got.column);
      check_field("floor_row", e.floor_row, got.floor_row);
      check_field("mirror_row", e.mirror_row, got.mirror_row);
      check_field("pixel_valid", e.pix_valid, got.pix_valid);
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [CFG_W-1:0]          cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [COORD_W-1:0]        row_i;
  logic [COORD_W-1:0]        column_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [FLOOR_TEX_LOG2-1:0] floor_tex_u_o;
  logic [FLOOR_TEX_LOG2-1:0] floor_tex_v_o;
  logic [CEIL_TEX_LOG2-1:0]  ceil_tex_u_o;
  logic [CEIL_TEX_LOG2-1:0]  ceil_tex_v_o;
  logic [COORD_W-1:0]        out_column_o;
  logic [COORD_W-1:0]        floor_row_o;
  logic [COORD_W-1:0]        mirror_row_o;
  logic                      pixel_valid_o;

  texcoord_tracker tracker;
  int              in_gap_pct;
  int              stall_pct;
  int              quiet_cycles = 0;

  floor_ceiling_texcoord_gen_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .row_i         (row_i),
    .column_i      (column_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .floor_tex_u_o (floor_tex_u_o),
    .floor_tex_v_o (floor_tex_v_o),
    .ceil_tex_u_o  (ceil_tex_u_o),
    .ceil_tex_v_o  (ceil_tex_v_o),
    .out_column_o  (out_column_o),
    .floor_row_o   (floor_row_o),
    .mirror_row_o  (mirror_row_o),
    .pixel_valid_o (pixel_valid_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int pick(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic view_cfg_t make_view(input int px, input int py, input int lx,
                                          input int ly, input int sx, input int sy,
                                          input int w, input int h);
    view_cfg_t v;
    v.player_x = POS_W'(px);
    v.player_y = POS_W'(py);
    v.left_x   = RAY_W'(lx);
    v.left_y   = RAY_W'(ly);
    v.span_x   = SPAN_W'(sx);
    v.span_y   = SPAN_W'(sy);
    v.width    = DIM_W'(w);
    v.height   = DIM_W'(h);
    return v;
  endfunction

  function automatic view_cfg_t random_view();
    int w;
    w = ($urandom_range(0, 9) == 0) ? 0 : pick(1, 4096);
    return make_view(pick(0, 67108863), pick(0, 67108863), pick(-131072, 131072),
                     pick(-131072, 131072), pick(-262144, 262144),
                     pick(-262144, 262144), w, pick(2, 4096));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    tracker.set_reg(idx, data);
  endtask

  // registers change only once every pending result is out
  task automatic load_view(input view_cfg_t v);
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(REG_PLAYER_X, CFG_W'(v.player_x));
    write_reg(REG_PLAYER_Y, CFG_W'(v.player_y));
    write_reg(REG_LEFT_RAY_X, CFG_W'(v.left_x));
    write_reg(REG_LEFT_RAY_Y, CFG_W'(v.left_y));
    write_reg(REG_RAY_SPAN_X, CFG_W'(v.span_x));
    write_reg(REG_RAY_SPAN_Y, CFG_W'(v.span_y));
    write_reg(REG_SCREEN_WIDTH, CFG_W'(v.width));
    write_reg(REG_SCREEN_HEIGHT, CFG_W'(v.height));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_i      <= r;
    column_i   <= c;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_request(r, c);
  endtask

  // mostly runs of up to 24 pixels from column zero, some on horizon and off-screen rows,
  // the rest broken rows starting mid-way
  task automatic run_random_phase(input int count);
    int done_here;
    int h;
    int r;
    int n;
    int first;
    int k;
    done_here = 0;
    h = int'(tracker.view.height);
    while (done_here < count) begin
      first = 0;
      n = $urandom_range(1, 24);
      k = $urandom_range(0, 99);
      if (k < 65) begin
        r = $urandom_range(0, h - 1);
      end else if (k < 75) begin
        r = h / 2;
      end else if (k < 83) begin
        r = $urandom_range((h > 4095) ? 4095 : h, 4095);
      end else begin
        r = $urandom_range(0, 4095);
        first = $urandom_range(1, 4095);
        n = $urandom_range(1, 4);
      end
      if (n > count - done_here) n = count - done_here;
      for (int i = 0; i < n; i++) send_pixel(COORD_W'(r), COORD_W'(first + i));
      done_here += n;
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    texel_set_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.floor_u    = int'(floor_tex_u_o);
      got.floor_v    = int'(floor_tex_v_o);
      got.ceil_u     = int'(ceil_tex_u_o);
      got.ceil_v     = int'(ceil_tex_v_o);
      got.column     = int'(out_column_o);
      got.floor_row  = int'(floor_row_o);
      got.mirror_row = int'(mirror_row_o);
      got.pix_valid  = int'(pixel_valid_o);
      tracker.compare_texels(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    tracker     = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    row_i       = '0;
    column_i    = '0;
    in_gap_pct  = 15;
    stall_pct   = 15;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, first request has a nonzero column with no set-up
    send_pixel(12'd5, 12'd3);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd240, 12'd0);
    send_pixel(12'd240, 12'd7);
    send_pixel(12'd479, 12'd0);
    send_pixel(12'd479, 12'd1);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd4095, 12'd4095);

    // zero width, smallest height, negative rays so positions go negative
    load_view(make_view(0, 0, -131072, -131072, 262144, -262144, 0, 2));
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd2, 12'd0);
    send_pixel(12'd2, 12'd5);
    send_pixel(12'd3000, 12'd0);
    send_pixel(12'd4095, 12'd4095);

    // everything at the top of its random range
    load_view(make_view(67108863, 67108863, 131072, 131072, 262144, 262144, 4096, 4096));
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd2048, 12'd0);
    send_pixel(12'd2047, 12'd0);
    send_pixel(12'd2047, 12'd1);
    send_pixel(12'd2049, 12'd0);
    send_pixel(12'd2049, 12'd4095);
    send_pixel(12'd4095, 12'd0);

    for (int ph = 0; ph < 8; ph++) begin
      load_view(random_view());
      case ($urandom_range(0, 2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 10;
        default: in_gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 35;
      endcase
      if (ph == 7) begin
        in_gap_pct = 0;
        stall_pct  = 0;
      end
      run_random_phase(128);
    end

    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
